>>> hw/rtl/dsdl_pkg.sv
// Package for the depth-sorted draw list: sizes, opcodes, status codes and
// the command and status structs between controller and datapath. No dependencies.
package dsdl_pkg;
    localparam int Capacity = 64;
    localparam int PosW = 6;
    localparam int CntW = 7;
    localparam int HndW = 32;
    localparam int KeyW = 16;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_SET = 3'd1;
    localparam logic [2:0] OP_GET = 3'd2;
    localparam logic [2:0] OP_DEL_AT = 3'd3;
    localparam logic [2:0] OP_DEL_HND = 3'd4;
    localparam logic [2:0] OP_SORT = 3'd5;
    localparam logic [2:0] OP_SPARE0 = 3'd6;
    localparam logic [2:0] OP_SPARE1 = 3'd7;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        MC_NONE,
        MC_READ,
        MC_WRITE_IN,
        MC_WRITE_HOLD,
        MC_WRITE_READ
    } t_mcmd;

    typedef struct packed {
        t_mcmd           mem_op;
        logic [PosW-1:0] rd_addr;
        logic [PosW-1:0] wr_addr;
        logic            hold_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [HndW-1:0] rd_handle;
        logic [KeyW-1:0] rd_key;
        logic [HndW-1:0] hold_handle;
        logic [KeyW-1:0] hold_key;
    } t_dp_stat;
endpackage

>>> hw/rtl/dsdl_if.sv
// Valid/ready channel interfaces for the draw list's input and result words.
// Depends on dsdl_pkg.
interface dsdl_in_if import dsdl_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [2:0]             opcode;
    logic [HndW-1:0]        handle;
    logic signed [KeyW-1:0] depth_key;
    logic [PosW-1:0]        position;
    logic [PosW-1:0]        range_end;
    modport source (output valid, opcode, handle, depth_key, position, range_end,
                    input ready);
    modport sink (input valid, opcode, handle, depth_key, position, range_end,
                  output ready);
endinterface

interface dsdl_out_if import dsdl_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [HndW-1:0]        out_handle;
    logic signed [KeyW-1:0] out_key;
    logic [CntW-1:0]        item_count;
    logic                   modified;
    modport source (output valid, status, out_handle, out_key, item_count, modified,
                    input ready);
    modport sink (input valid, status, out_handle, out_key, item_count, modified,
                  output ready);
endinterface

>>> hw/rtl/dsdl_datapath.sv
// Datapath of the draw list: handle and key memories with registered reads
// and a held entry register. Depends on dsdl_pkg.
module dsdl_datapath import dsdl_pkg::*; (
    input  logic            i_clk,
    input  t_dp_cmd         i_cmd,
    input  logic [HndW-1:0] i_handle,
    input  logic [KeyW-1:0] i_key,
    output t_dp_stat        o_stat
);
    logic [HndW-1:0] r_hmem [Capacity];
    logic [KeyW-1:0] r_kmem [Capacity];
    logic [HndW-1:0] r_rd_h, r_hold_h;
    logic [KeyW-1:0] r_rd_k, r_hold_k;
    logic [HndW-1:0] n_wh;
    logic [KeyW-1:0] n_wk;

    always_comb begin
        case (i_cmd.mem_op)
            MC_WRITE_IN: begin
                n_wh = i_handle;
                n_wk = i_key;
            end
            MC_WRITE_HOLD: begin
                n_wh = r_hold_h;
                n_wk = r_hold_k;
            end
            default: begin
                n_wh = r_rd_h;
                n_wk = r_rd_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_op == MC_WRITE_IN || i_cmd.mem_op == MC_WRITE_HOLD
            || i_cmd.mem_op == MC_WRITE_READ) begin
            r_hmem[i_cmd.wr_addr] <= n_wh;
            r_kmem[i_cmd.wr_addr] <= n_wk;
        end
        r_rd_h <= r_hmem[i_cmd.rd_addr];
        r_rd_k <= r_kmem[i_cmd.rd_addr];
        if (i_cmd.hold_load) begin
            r_hold_h <= r_rd_h;
            r_hold_k <= r_rd_k;
        end
    end

    assign o_stat = '{rd_handle: r_rd_h, rd_key: r_rd_k,
                      hold_handle: r_hold_h, hold_key: r_hold_k};
endmodule

>>> hw/rtl/dsdl_ctrl.sv
// Controller of the draw list: sequences append, set, get, deletes, search and
// insertion sort over the datapath memories. Depends on dsdl_pkg.
module dsdl_ctrl import dsdl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_opcode,
    input  logic [HndW-1:0]        i_handle,
    input  logic [PosW-1:0]        i_position,
    input  logic [PosW-1:0]        i_range_end,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [1:0]             o_status,
    output logic [HndW-1:0]        o_out_handle,
    output logic [KeyW-1:0]        o_out_key,
    output logic [CntW-1:0]        o_item_count,
    output logic                   o_modified,
    output t_dp_cmd                o_cmd,
    input  t_dp_stat               i_stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_GET_R, S_SRCH_W, S_SRCH_C, S_SHIFT_W, S_SHIFT,
        S_SORT_I, S_SORT_LD, S_SORT_J, S_SORT_C, S_SORT_PUT, S_OUT
    } t_state;

    t_state          r_state;
    logic [CntW-1:0] r_count;
    logic            r_mod;
    logic [PosW-1:0] r_i, r_j, r_lo, r_hi;
    logic [HndW-1:0] r_hnd;
    logic [1:0]      r_status;
    logic [HndW-1:0] r_oh;
    logic [KeyW-1:0] r_ok;
    logic            r_ov;
    logic [1:0]      r_res_status;
    logic [HndW-1:0] r_res_handle;
    logic [KeyW-1:0] r_res_key;
    logic [CntW-1:0] r_res_count;
    logic            r_res_mod;
    logic [CntW-1:0] n_hi;
    logic [CntW-1:0] n_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_status = r_res_status;
    assign o_out_handle = r_res_handle;
    assign o_out_key = r_res_key;
    assign o_item_count = r_res_count;
    assign o_modified = r_res_mod;
    assign n_last = r_count - CntW'(1);
    assign n_hi = ({1'b0, i_range_end} > n_last) ? n_last : {1'b0, i_range_end};

    always_comb begin
        o_cmd = '{mem_op: MC_NONE, rd_addr: r_i, wr_addr: r_i, hold_load: 1'b0};
        case (r_state)
            S_IDLE: begin
                o_cmd.rd_addr = i_position;
                o_cmd.wr_addr = (i_opcode == OP_APPEND) ? r_count[PosW-1:0] : i_position;
                if (i_in_valid && o_in_ready) begin
                    if (i_opcode == OP_APPEND && r_count < CntW'(Capacity)) begin
                        o_cmd.mem_op = MC_WRITE_IN;
                    end
                    if (i_opcode == OP_SET && {1'b0, i_position} < r_count) begin
                        o_cmd.mem_op = MC_WRITE_IN;
                    end
                end
            end
            S_SRCH_W, S_SRCH_C: o_cmd.rd_addr = r_i + PosW'(1);
            S_SHIFT_W: o_cmd.rd_addr = r_i + PosW'(1);
            S_SHIFT: begin
                if ({1'b0, r_i} + CntW'(1) < r_count) begin
                    o_cmd.mem_op = MC_WRITE_READ;
                end
            end
            S_SORT_I: o_cmd.rd_addr = r_i;
            S_SORT_LD: begin
                o_cmd.hold_load = 1'b1;
                o_cmd.rd_addr = r_j - PosW'(1);
            end
            S_SORT_J: o_cmd.rd_addr = r_j - PosW'(1);
            S_SORT_C: begin
                o_cmd.wr_addr = r_j;
                o_cmd.rd_addr = r_j - PosW'(2);
                if (r_j != r_lo && $signed(i_stat.rd_key) > $signed(i_stat.hold_key)) begin
                    o_cmd.mem_op = MC_WRITE_READ;
                end
            end
            S_SORT_PUT: begin
                o_cmd.wr_addr = r_j;
                o_cmd.mem_op = MC_WRITE_HOLD;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_mod <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_status <= ST_OK;
                        r_oh <= '0;
                        r_ok <= '0;
                        r_i <= i_position;
                        r_hnd <= i_handle;
                        r_state <= S_OUT;
                        case (i_opcode)
                            OP_APPEND: begin
                                if (r_count >= CntW'(Capacity)) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_count <= r_count + CntW'(1);
                                    r_mod <= 1'b1;
                                end
                            end
                            OP_SET: begin
                                if ({1'b0, i_position} >= r_count) begin
                                    r_status <= ST_BADPOS;
                                end else begin
                                    r_mod <= 1'b1;
                                end
                            end
                            OP_GET: begin
                                if ({1'b0, i_position} >= r_count) begin
                                    r_status <= ST_BADPOS;
                                end else begin
                                    r_state <= S_GET_R;
                                end
                            end
                            OP_DEL_AT: begin
                                if ({1'b0, i_position} >= r_count) begin
                                    r_status <= ST_BADPOS;
                                end else begin
                                    r_state <= S_SHIFT_W;
                                end
                            end
                            OP_DEL_HND: begin
                                if (i_handle != '0) begin
                                    r_status <= ST_NOTFOUND;
                                    r_i <= '1;
                                    if (r_count != '0) begin
                                        r_state <= S_SRCH_W;
                                    end
                                end
                            end
                            OP_SORT: begin
                                r_mod <= 1'b0;
                                if ({1'b0, i_position} >= r_count) begin
                                    r_status <= ST_BADPOS;
                                end else if ({1'b0, i_position} < n_hi) begin
                                    r_lo <= i_position;
                                    r_hi <= n_hi[PosW-1:0];
                                    r_i <= i_position + PosW'(1);
                                    r_state <= S_SORT_I;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_GET_R: begin
                    r_oh <= i_stat.rd_handle;
                    r_ok <= i_stat.rd_key;
                    r_state <= S_OUT;
                end
                S_SRCH_W: begin
                    r_i <= r_i + PosW'(1);
                    r_state <= S_SRCH_C;
                end
                S_SRCH_C: begin
                    if (i_stat.rd_handle == r_hnd) begin
                        r_status <= ST_OK;
                        r_state <= S_SHIFT_W;
                    end else if ({1'b0, r_i} + CntW'(1) >= r_count) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SRCH_W;
                    end
                end
                S_SHIFT: begin
                    if ({1'b0, r_i} + CntW'(1) >= r_count) begin
                        r_count <= r_count - CntW'(1);
                        r_state <= S_OUT;
                    end else begin
                        r_i <= r_i + PosW'(1);
                        r_state <= S_SHIFT_W;
                    end
                end
                S_SHIFT_W: r_state <= S_SHIFT;
                S_SORT_I: begin
                    r_j <= r_i;
                    r_state <= S_SORT_LD;
                end
                S_SORT_LD: r_state <= S_SORT_C;
                S_SORT_J: r_state <= S_SORT_C;
                S_SORT_C: begin
                    if (o_cmd.mem_op == MC_WRITE_READ) begin
                        r_j <= r_j - PosW'(1);
                        r_state <= S_SORT_J;
                    end else begin
                        r_state <= S_SORT_PUT;
                    end
                end
                S_SORT_PUT: begin
                    if (r_i == r_hi) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i <= r_i + PosW'(1);
                        r_state <= S_SORT_I;
                    end
                end
                S_OUT: begin
                    if (!r_ov || i_out_ready) begin
                        r_ov <= 1'b1;
                        r_res_status <= r_status;
                        r_res_handle <= r_oh;
                        r_res_key <= r_ok;
                        r_res_count <= r_count;
                        r_res_mod <= r_mod;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(Capacity)) else $error("Entry count exceeds capacity.");
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("Ready while busy.");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |=> (r_ov && $stable(r_res_count) && $stable(r_res_status)))
        else $error("Result word changed while stalled.");
endmodule

>>> hw/rtl/depth_sorted_draw_list_unit.sv
// Depth-sorted draw list: a list of up to 64 handle and key entries in two
// memories, run by a controller. It takes a new command word only when idle;
// deletes, handle searches and sorts step through the entries one read at a
// time, since both memories share a single read address. Depends on dsdl_pkg,
// dsdl_if.
module depth_sorted_draw_list_unit import dsdl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dsdl_in_if.sink    i_in,
    dsdl_out_if.source o_out
);
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    dsdl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .i_opcode(i_in.opcode), .i_handle(i_in.handle),
        .i_position(i_in.position), .i_range_end(i_in.range_end),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .o_status(o_out.status), .o_out_handle(o_out.out_handle),
        .o_out_key(o_out.out_key), .o_item_count(o_out.item_count),
        .o_modified(o_out.modified), .o_cmd(w_cmd), .i_stat(w_stat)
    );

    dsdl_datapath u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_handle(i_in.handle),
        .i_key(i_in.depth_key), .o_stat(w_stat)
    );
endmodule

>>> tb/sv/depth_sorted_draw_list_unit_chk.sv
// Checker for the depth-sorted draw list: watches the input and result channels,
// predicts every result word and compares it, showing each field on a mismatch. Depends on dsdl_pkg, dsdl_if.
`timescale 1ns / 100ps
module depth_sorted_draw_list_unit_chk import dsdl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsdl_in_if          i_in,
    dsdl_out_if         i_out,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [1:0]             status;
        logic [HndW-1:0]        handle;
        logic signed [KeyW-1:0] key;
        logic [CntW-1:0]        count;
        logic                   modified;
    } t_result;

    logic [HndW-1:0]        list_hnd [Capacity];
    logic signed [KeyW-1:0] list_key [Capacity];
    int                     list_len;
    logic                   list_mod;
    t_result                expected_q [$];

    assign o_pending = expected_q.size();

    function automatic void drop_entry(int p);
        for (int i = p; i + 1 < list_len; i++) begin
            list_hnd[i] = list_hnd[i + 1];
            list_key[i] = list_key[i + 1];
        end
        list_len--;
    endfunction

    function automatic t_result apply_word(logic [2:0] op, logic [HndW-1:0] h,
                                           logic signed [KeyW-1:0] k,
                                           int p, int e);
        t_result r;
        logic [HndW-1:0] th;
        logic signed [KeyW-1:0] tk;
        int j;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_APPEND: begin
                if (list_len >= Capacity) begin
                    r.status = ST_FULL;
                end else begin
                    list_hnd[list_len] = h;
                    list_key[list_len] = k;
                    list_len++;
                    list_mod = 1'b1;
                end
            end
            OP_SET: begin
                if (p >= list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    list_hnd[p] = h;
                    list_key[p] = k;
                    list_mod = 1'b1;
                end
            end
            OP_GET: begin
                if (p >= list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.handle = list_hnd[p];
                    r.key = list_key[p];
                end
            end
            OP_DEL_AT: begin
                if (p >= list_len) r.status = ST_BADPOS;
                else drop_entry(p);
            end
            OP_DEL_HND: begin
                if (h != 0) begin
                    r.status = ST_NOTFOUND;
                    for (int i = 0; i < list_len; i++) begin
                        if (list_hnd[i] == h) begin
                            drop_entry(i);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            OP_SORT: begin
                if (p >= list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    if (e > list_len - 1) e = list_len - 1;
                    for (int i = p + 1; i <= e; i++) begin
                        th = list_hnd[i];
                        tk = list_key[i];
                        j = i;
                        while (j > p && list_key[j - 1] > tk) begin
                            list_hnd[j] = list_hnd[j - 1];
                            list_key[j] = list_key[j - 1];
                            j--;
                        end
                        list_hnd[j] = th;
                        list_key[j] = tk;
                    end
                end
                list_mod = 1'b0;
            end
            default: ;
        endcase
        r.count = CntW'(list_len);
        r.modified = list_mod;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            list_len <= 0;
            list_mod <= 1'b0;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                expected_q.push_back(apply_word(i_in.opcode, i_in.handle, i_in.depth_key,
                                                int'(i_in.position), int'(i_in.range_end)));
            end
            if (i_out.valid && i_out.ready) begin
                got = {i_out.status, i_out.out_handle, i_out.out_key, i_out.item_count,
                       i_out.modified};
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10) $display("Unexpected result word %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10) begin
                            $display("Mismatch: status %0d/%0d handle %h/%h key %0d/%0d",
                                     want.status, got.status, want.handle, got.handle,
                                     want.key, got.key);
                            $display("          count %0d/%0d modified %0d/%0d",
                                     want.count, got.count, want.modified, got.modified);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> tb/sv/depth_sorted_draw_list_unit_tb.sv
// Top of the draw list testbench: clock, reset, directed and random command
// words, receiver stalls and the verdict. Depends on dsdl_pkg, dsdl_if and the checker.
`timescale 1ns / 100ps
module depth_sorted_draw_list_unit_tb;
    import dsdl_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   hold_cycles;
    bit   hold_req = 1'b0;
    bit   hold_seen;
    bit   stall_random = 1'b1;
    logic [HndW-1:0] used_hnd [$];

    dsdl_in_if  in_ch ();
    dsdl_out_if out_ch ();

    depth_sorted_draw_list_unit u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    depth_sorted_draw_list_unit_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    // The receiver stalls at random or not at all, or holds off entirely for a long stretch once asked.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= 0;
            hold_seen <= 1'b0;
        end else if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_cycles <= 400;
            out_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_random) begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_word(logic [2:0] op, logic [HndW-1:0] h, logic [KeyW-1:0] k,
                             logic [PosW-1:0] p, logic [PosW-1:0] e);
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.handle <= h;
        in_ch.depth_key <= k;
        in_ch.position <= p;
        in_ch.range_end <= e;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (op == OP_APPEND || op == OP_SET) used_hnd.push_back(h);
    endtask

    task automatic idle_gap(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic random_word();
        int sel;
        logic [HndW-1:0] h;
        logic [KeyW-1:0] k;
        sel = $urandom_range(0, 99);
        h = $urandom();
        if ($urandom_range(0, 3) == 0) h = $urandom_range(1, 8);
        k = KeyW'($urandom());
        if ($urandom_range(0, 2) == 0) k = KeyW'($urandom_range(0, 7) - 3);
        if (sel < 30) begin
            send_word(OP_APPEND, h, k, PosW'($urandom()), PosW'($urandom()));
        end else if (sel < 42) begin
            send_word(OP_SET, h, k, PosW'($urandom_range(0, 63)), PosW'($urandom()));
        end else if (sel < 57) begin
            send_word(OP_GET, h, k, PosW'($urandom_range(0, 63)), PosW'($urandom()));
        end else if (sel < 65) begin
            send_word(OP_DEL_AT, h, k, PosW'($urandom_range(0, 63)), PosW'($urandom()));
        end else if (sel < 75) begin
            if (used_hnd.size() > 0 && $urandom_range(0, 3) != 0)
                h = used_hnd[$urandom_range(0, used_hnd.size() - 1)];
            if ($urandom_range(0, 15) == 0) h = '0;
            send_word(OP_DEL_HND, h, k, PosW'($urandom()), PosW'($urandom()));
        end else if (sel < 92) begin
            send_word(OP_SORT, h, k, PosW'($urandom_range(0, 40)),
                      PosW'($urandom_range(0, 63)));
        end else begin
            send_word(($urandom_range(0, 1) != 0) ? OP_SPARE1 : OP_SPARE0, h, k,
                      PosW'($urandom()), PosW'($urandom()));
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_APPEND;
        in_ch.handle = '0;
        in_ch.depth_key = '0;
        in_ch.position = '0;
        in_ch.range_end = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-list errors, field extremes, deletes, unused opcodes, full list and sorts.
        send_word(OP_GET, '0, '0, '0, '0);
        send_word(OP_SORT, '0, '0, '0, 6'd63);
        send_word(OP_DEL_HND, 32'd5, '0, '0, '0);
        send_word(OP_APPEND, 32'hFFFF_FFFF, 16'sh7FFF, 6'd63, 6'd63);
        send_word(OP_APPEND, 32'h0000_0001, 16'sh8000, '0, '0);
        send_word(OP_APPEND, 32'h0000_0002, 16'sh7FFF, '0, '0);
        send_word(OP_GET, '0, '0, 6'd1, '0);
        send_word(OP_SET, 32'hA5A5_5A5A, 16'sh0000, 6'd2, '0);
        send_word(OP_SET, '0, '0, 6'd63, '0);
        send_word(OP_DEL_HND, '0, '0, '0, '0);
        send_word(OP_DEL_HND, 32'h1234_5678, '0, '0, '0);
        send_word(OP_SORT, '0, '0, 6'd2, 6'd1);
        send_word(OP_SORT, '0, '0, '0, 6'd63);
        send_word(OP_DEL_AT, '0, '0, 6'd63, '0);
        send_word(OP_DEL_HND, 32'hFFFF_FFFF, '0, '0, '0);
        send_word(OP_DEL_AT, '0, '0, '0, '0);
        send_word(OP_SPARE0, '0, '0, '0, '0);
        send_word(OP_SPARE1, '1, '1, '1, '1);
        for (int i = 0; i < 66; i++)
            send_word(OP_APPEND, $urandom(), 16'(63 - i), '0, '0);
        send_word(OP_SORT, '0, '0, '0, 6'd63);
        send_word(OP_GET, '0, '0, 6'd63, '0);
        idle_gap(1);

        // The receiver holds off long enough for the block to back up.
        hold_req <= 1'b1;
        for (int i = 0; i < 20; i++) random_word();
        idle_gap(1);
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < 460; n++) begin
            if ($urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 12));
            if (n == 200) stall_random = 1'b0;
            if (n == 300) stall_random = 1'b1;
            random_word();
        end
        idle_gap(1);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
